// File: design/bcp_pkg.sv
// Package for the planar-to-chunky palette converter.
// Shared types, constants and the RGB565 expansion function; no dependencies.
package bcp_pkg;

    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_PLANES   = 8;
    localparam int DEF_PALETTE_SIZE = 256;

    localparam logic [2:0] DEPTH_DIRECT = 3'd4;

    localparam logic [3:0] ADDR_DEPTH_CODE  = 4'h0;
    localparam logic [3:0] ADDR_LINE_PLANAR = 4'h4;
    localparam logic [3:0] ADDR_ROW_WIDTH   = 4'h8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CAP,
        S_PRD,
        S_PCAP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic take;
        logic cap_plane;
        logic rd_pix;
        logic cap_pix;
        logic next_pix;
    } cmd_t;

    typedef struct packed {
        logic go_out;
        logic go_load;
        logic go_pix;
        logic load_last;
        logic pix_last;
    } stat_t;

    // (v*510 + 31) / 62: halve, then divide by 31 with a reciprocal multiply
    function automatic logic [7:0] scale5(input logic [4:0] v);
        logic [15:0] t;
        logic [27:0] m;
        begin
            t = 16'(v) * 16'd510 + 16'd31;
            m = 28'(t[15:1]) * 28'd8457;
            return m[25:18];
        end
    endfunction

    // (v*510 + 63) / 126: halve, then divide by 63 with a reciprocal multiply
    function automatic logic [7:0] scale6(input logic [5:0] v);
        logic [15:0] t;
        logic [29:0] m;
        begin
            t = 16'(v) * 16'd510 + 16'd63;
            m = 30'(t[15:1]) * 30'd16645;
            return m[27:20];
        end
    endfunction

    function automatic logic [23:0] rgb565_to_888(input logic [15:0] v);
        begin
            return {scale5(v[15:11]), scale6(v[10:5]), scale5(v[4:0])};
        end
    endfunction

endpackage

// File: design/bcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/bcp_ctrl.sv
// Controller state machine for the planar-to-chunky palette converter.
// Uses bcp_pkg for state, command and status types.
module bcp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  bcp_pkg::stat_t stat,
    output bcp_pkg::cmd_t  cmd
);

    bcp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            bcp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    priority if (stat.go_out)
                        state_next = bcp_pkg::S_OUT;
                    else if (stat.go_load)
                        state_next = bcp_pkg::S_RD;
                    else if (stat.go_pix)
                        state_next = bcp_pkg::S_PRD;
                    else
                        state_next = bcp_pkg::S_IDLE;
                end
            end
            bcp_pkg::S_RD:
            begin
                state_next = bcp_pkg::S_CAP;
            end
            bcp_pkg::S_CAP:
            begin
                cmd.cap_plane = 1'b1;
                state_next    = stat.load_last ? bcp_pkg::S_PRD : bcp_pkg::S_RD;
            end
            bcp_pkg::S_PRD:
            begin
                cmd.rd_pix = 1'b1;
                state_next = bcp_pkg::S_PCAP;
            end
            bcp_pkg::S_PCAP:
            begin
                cmd.cap_pix = 1'b1;
                state_next  = bcp_pkg::S_OUT;
            end
            bcp_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.pix_last)
                    begin
                        state_next = bcp_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.next_pix = 1'b1;
                        state_next   = bcp_pkg::S_PRD;
                    end
                end
            end
            default:
            begin
                state_next = bcp_pkg::S_IDLE;
            end
        endcase
    end

    a_cap_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bcp_pkg::S_CAP |-> $past(state_reg) == bcp_pkg::S_RD)
        else $error("plane capture without read");

    a_pcap_after_prd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bcp_pkg::S_PCAP |-> $past(state_reg) == bcp_pkg::S_PRD)
        else $error("palette capture without read");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while word pending");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && stat.pix_last |=> state_reg == bcp_pkg::S_IDLE)
        else $error("last word did not return to idle");

endmodule

// File: design/bcp_dp.sv
// Datapath for the planar-to-chunky palette converter: config registers,
// counters, plane store, palette and output register. Uses bcp_pkg, bcp_ram.
module bcp_dp #(
    parameter int MAX_WIDTH    = bcp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_PLANES   = bcp_pkg::DEF_MAX_PLANES,
    parameter int PALETTE_SIZE = bcp_pkg::DEF_PALETTE_SIZE
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    input  logic           func,
    input  logic [15:0]    data_word,
    input  logic [7:0]     entry_index,
    input  logic [23:0]    entry_rgb,
    input  bcp_pkg::cmd_t  cmd,
    output bcp_pkg::stat_t stat,
    output logic [23:0]    pixel_rgb,
    output logic [7:0]     pixel_index,
    output logic           row_end,
    output logic           last
);

    localparam int GROUPS_MAX  = (MAX_WIDTH + 15) / 16;
    localparam int STORE_DEPTH = (MAX_PLANES - 1) * GROUPS_MAX + 1;
    localparam int SAW  = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;
    localparam int PAW  = $clog2(PALETTE_SIZE);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = WW > 11 ? WW : 11;
    localparam int CMPW = WW + 2;
    localparam int GIW  = GROUPS_MAX > 1 ? $clog2(GROUPS_MAX) : 1;
    localparam int WIW  = $clog2(GROUPS_MAX * 16);
    localparam int PW   = MAX_PLANES > 1 ? $clog2(MAX_PLANES) : 1;
    localparam int NSV  = MAX_PLANES > 1 ? MAX_PLANES - 1 : 1;

    logic [2:0]  depth_reg;
    logic        planar_reg;
    logic [10:0] width_reg;

    logic [PW-1:0]  p_reg;
    logic [GIW-1:0] g_reg;
    logic [WIW-1:0] w_reg;

    logic [GIW-1:0] cur_g_reg;
    logic [15:0]    word_reg;
    logic [PW-1:0]  q_reg;
    logic [3:0]     k_reg;
    logic [15:0]    plane_reg [NSV];

    logic [PALETTE_SIZE-1:0] pal_valid_reg;
    logic                    pv_reg;
    logic [7:0]              pidx_reg;

    logic [23:0] rgb_reg;
    logic [7:0]  idx_reg;
    logic        rend_reg;
    logic        last_reg;

    logic           cfg_wr;
    logic [CW-1:0]  rw_wide;
    logic [WW-1:0]  rw;
    logic [WW:0]    rw15;
    logic [CMPW-1:0] grp16;
    logic [CMPW-1:0] rw_m1;
    logic [CMPW-1:0] grp_ext;
    logic [3:0]     planes;
    logic           pal_mode;
    logic           emit;
    logic           img_take;
    logic           g_wrap;
    logic [CMPW-1:0] w_ext;
    logic [CMPW-1:0] x_ext;
    logic [7:0]     pix_idx;
    logic           pix_ok;

    logic           st_we;
    logic [SAW-1:0] st_waddr;
    logic [SAW-1:0] st_raddr;
    logic [15:0]    st_rdata;
    logic           pal_we;
    logic [23:0]    pal_rdata;

    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr)
            bcp_pkg::ADDR_DEPTH_CODE:  prdata = {29'd0, depth_reg};
            bcp_pkg::ADDR_LINE_PLANAR: prdata = {31'd0, planar_reg};
            bcp_pkg::ADDR_ROW_WIDTH:   prdata = {21'd0, width_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign rw_wide = (width_reg == 11'd0) ? CW'(1)
                   : (CW'(width_reg) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_reg);
    assign rw      = rw_wide[WW-1:0];
    assign rw15    = {1'b0, rw} + (WW + 1)'(15);
    assign grp_ext = CMPW'(rw15[WW:4]);
    assign grp16   = {grp_ext[CMPW-5:0], 4'd0};
    assign rw_m1   = CMPW'(rw) - CMPW'(1);

    assign planes   = 4'd1 << depth_reg[1:0];
    assign pal_mode = (depth_reg < bcp_pkg::DEPTH_DIRECT) && (planes <= 4'(MAX_PLANES));
    assign emit     = 4'(p_reg) == planes - 4'd1;
    assign img_take = cmd.take && !func;
    assign g_wrap   = CMPW'(g_reg) + CMPW'(1) >= grp_ext;
    assign w_ext    = CMPW'(w_reg);
    assign x_ext    = CMPW'({cur_g_reg, k_reg});

    assign stat.go_out    = !func && depth_reg == bcp_pkg::DEPTH_DIRECT && w_ext < CMPW'(rw);
    assign stat.go_load   = !func && pal_mode && emit && planes != 4'd1;
    assign stat.go_pix    = !func && pal_mode && emit && planes == 4'd1;
    assign stat.load_last = 4'(q_reg) == planes - 4'd2;
    assign stat.pix_last  = last_reg;

    always_comb
    begin
        pix_idx = 8'd0;
        for (int i = 0; i < MAX_PLANES; i++)
        begin
            if (4'(i) == planes - 4'd1)
                pix_idx[i] = word_reg[4'd15 - k_reg];
            else if (4'(i) < planes - 4'd1 && i < NSV)
                pix_idx[i] = plane_reg[i][4'd15 - k_reg];
        end
    end

    assign pix_ok = {1'b0, pix_idx} < 9'(PALETTE_SIZE);

    assign st_we    = img_take && pal_mode && !emit;
    assign st_waddr = SAW'(32'(p_reg) * GROUPS_MAX + 32'(g_reg));
    assign st_raddr = SAW'(32'(q_reg) * GROUPS_MAX + 32'(cur_g_reg));

    bcp_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (data_word),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign pal_we = cmd.take && func && ({1'b0, entry_index} < 9'(PALETTE_SIZE));

    bcp_ram #(.WIDTH(24), .DEPTH(PALETTE_SIZE)) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (entry_index[PAW-1:0]),
        .wdata (entry_rgb),
        .raddr (pix_idx[PAW-1:0]),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= 3'd2;
            planar_reg    <= 1'b0;
            width_reg     <= 11'd320;
            p_reg         <= '0;
            g_reg         <= '0;
            w_reg         <= '0;
            pal_valid_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr)
                    bcp_pkg::ADDR_DEPTH_CODE:  depth_reg  <= pwdata[2:0];
                    bcp_pkg::ADDR_LINE_PLANAR: planar_reg <= pwdata[0];
                    bcp_pkg::ADDR_ROW_WIDTH:   width_reg  <= pwdata[10:0];
                    default:                   ;
                endcase
                if (paddr == bcp_pkg::ADDR_DEPTH_CODE || paddr == bcp_pkg::ADDR_LINE_PLANAR
                    || paddr == bcp_pkg::ADDR_ROW_WIDTH)
                begin
                    p_reg <= '0;
                    g_reg <= '0;
                    w_reg <= '0;
                end
            end
            if (pal_we)
            begin
                pal_valid_reg[entry_index[PAW-1:0]] <= 1'b1;
            end
            if (img_take && depth_reg == bcp_pkg::DEPTH_DIRECT)
            begin
                w_reg <= (w_ext + CMPW'(1) >= grp16) ? '0 : w_reg + WIW'(1);
            end
            if (img_take && pal_mode)
            begin
                if (!planar_reg)
                begin
                    if (emit)
                    begin
                        p_reg <= '0;
                        g_reg <= g_wrap ? '0 : g_reg + GIW'(1);
                    end
                    else
                    begin
                        p_reg <= p_reg + PW'(1);
                    end
                end
                else
                begin
                    if (g_wrap)
                    begin
                        g_reg <= '0;
                        p_reg <= emit ? '0 : p_reg + PW'(1);
                    end
                    else
                    begin
                        g_reg <= g_reg + GIW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            word_reg  <= data_word;
            cur_g_reg <= g_reg;
            q_reg     <= '0;
            k_reg     <= 4'd0;
            rgb_reg   <= bcp_pkg::rgb565_to_888(data_word);
            idx_reg   <= 8'd0;
            rend_reg  <= w_ext == rw_m1;
            last_reg  <= 1'b1;
        end
        if (cmd.cap_plane)
        begin
            plane_reg[q_reg] <= st_rdata;
            q_reg            <= q_reg + PW'(1);
        end
        if (cmd.rd_pix)
        begin
            pv_reg   <= pix_ok && pal_valid_reg[pix_idx[PAW-1:0]];
            pidx_reg <= pix_idx;
        end
        if (cmd.cap_pix)
        begin
            rgb_reg  <= pv_reg ? pal_rdata : 24'd0;
            idx_reg  <= pidx_reg;
            rend_reg <= x_ext == rw_m1;
            last_reg <= (k_reg == 4'd15) || (x_ext == rw_m1);
        end
        if (cmd.next_pix)
        begin
            k_reg <= k_reg + 4'd1;
        end
    end

    assign pixel_rgb   = rgb_reg;
    assign pixel_index = idx_reg;
    assign row_end     = rend_reg;
    assign last        = last_reg;

endmodule

// File: design/bitplane_to_chunky_palette.sv
// Top level of the planar-to-chunky palette converter.
// Joins bcp_ctrl and bcp_dp; uses bcp_pkg for types and defaults.
//
// Input channel (in_valid/in_ready) takes one word: func 0 is an image word,
// func 1 writes palette entry entry_index with entry_rgb and gives no output.
// Output channel (out_valid/out_ready) gives the pixels of each word, with
// pixel_rgb, pixel_index, row_end on the last visible pixel of a row and last
// on the final pixel caused by one input word.
// The APB port sets depth_code (0x0), line_planar (0x4), row_width (0x8);
// a write to any of them restarts the row. Write it only while the block is idle.
// A direct-color word shows its pixel in the cycle after acceptance.
// A paletted word that completes a group first reads each earlier plane
// from the plane store (S_RD, then S_CAP); each pixel then goes through the
// palette RAM (S_PRD, then S_PCAP) and waits in S_OUT for its handshake.
// Other image words give no output. One word is handled at a time; in_ready
// is low until the last pixel of the current word is taken, so a stalled
// receiver holds the block. Reset restores the default registers, restarts
// the row and marks all palette entries invalid, so they give zero RGB.
module bitplane_to_chunky_palette #(
    parameter int MAX_WIDTH    = bcp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_PLANES   = bcp_pkg::DEF_MAX_PLANES,
    parameter int PALETTE_SIZE = bcp_pkg::DEF_PALETTE_SIZE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] data_word,
    input  logic [7:0]  entry_index,
    input  logic [23:0] entry_rgb,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] pixel_rgb,
    output logic [7:0]  pixel_index,
    output logic        row_end,
    output logic        last
);

    bcp_pkg::cmd_t  cmd;
    bcp_pkg::stat_t stat;

    assign pready = 1'b1;

    bcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bcp_dp #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_PLANES   (MAX_PLANES),
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .func        (func),
        .data_word   (data_word),
        .entry_index (entry_index),
        .entry_rgb   (entry_rgb),
        .cmd         (cmd),
        .stat        (stat),
        .pixel_rgb   (pixel_rgb),
        .pixel_index (pixel_index),
        .row_end     (row_end),
        .last        (last)
    );

endmodule
